### hdl/gdr_pkg.sv
// ----------------------------------------------------------------------------
// gdr_pkg - shared definitions for the Gregorian date register
// Constants, result codes and calendar helper functions.
// ----------------------------------------------------------------------------
package gdr_pkg;

  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DAYS_W  = 16;
  localparam int unsigned ORD_W   = 2;

  localparam logic [YEAR_W-1:0]  MAX_YEAR     = 14'd9999;
  localparam logic [YEAR_W-1:0]  FIRST_YEAR   = 14'd1582;
  localparam logic [MONTH_W-1:0] FIRST_MONTH  = 4'd10;
  localparam logic [YEAR_W-1:0]  RESET_YEAR   = 14'd2000;
  localparam logic [MONTH_W-1:0] RESET_MONTH  = 4'd1;
  localparam logic [DAY_W-1:0]   RESET_DAY    = 5'd1;
  localparam logic [MONTH_W-1:0] LAST_MONTH   = 4'd12;
  localparam logic [DAY_W-1:0]   LAST_DAY     = 5'd31;

  localparam logic OP_SET     = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic [ORD_W-1:0] ORD_EARLIER = 2'd0;
  localparam logic [ORD_W-1:0] ORD_EQUAL   = 2'd1;
  localparam logic [ORD_W-1:0] ORD_LATER   = 2'd2;

  // Divisibility by 25 by folding powers of two: 128 = 3 mod 25, 32 = 7 mod 25.
  function automatic logic div_by_25(input logic [YEAR_W-1:0] y);
    logic [8:0] s1;
    logic [7:0] s2;
    s1 = 9'(3 * y[13:7]) + 9'(y[6:0]);
    s2 = 8'(7 * s1[8:5]) + 8'(s1[4:0]);
    return (s2 == 8'd0) || (s2 == 8'd25) || (s2 == 8'd50) ||
           (s2 == 8'd75) || (s2 == 8'd100) || (s2 == 8'd125);
  endfunction

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic d25;
    d25 = div_by_25(y);
    return (y[1:0] == 2'b00) && (!d25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                    input logic [YEAR_W-1:0]  y);
    logic [DAY_W-1:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = is_leap(y) ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic date_valid(input logic [MONTH_W-1:0] m,
                                      input logic [DAY_W-1:0]   d,
                                      input logic [YEAR_W-1:0]  y);
    logic ok;
    ok = (m >= 4'd1) && (m <= LAST_MONTH);
    if ((y < FIRST_YEAR) || ((y == FIRST_YEAR) && (m < FIRST_MONTH))) ok = 1'b0;
    if ((d < 5'd1) || (d > month_length(m, y))) ok = 1'b0;
    return ok;
  endfunction

endpackage

### hdl/gdr_in_if.sv
// ----------------------------------------------------------------------------
// gdr_in_if - request channel of the Gregorian date register
// Valid/ready handshake with the set, advance and compare fields.
// ----------------------------------------------------------------------------
interface gdr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [gdr_pkg::MONTH_W-1:0] set_month;
  logic [gdr_pkg::DAY_W-1:0]   set_day;
  logic [gdr_pkg::YEAR_W-1:0]  set_year;
  logic [gdr_pkg::DAYS_W-1:0]  advance_days;
  logic [gdr_pkg::MONTH_W-1:0] cmp_month;
  logic [gdr_pkg::DAY_W-1:0]   cmp_day;
  logic [gdr_pkg::YEAR_W-1:0]  cmp_year;

  modport source (output valid, op, set_month, set_day, set_year, advance_days,
                  cmp_month, cmp_day, cmp_year, input ready);
  modport sink   (input valid, op, set_month, set_day, set_year, advance_days,
                  cmp_month, cmp_day, cmp_year, output ready);
endinterface

### hdl/gdr_out_if.sv
// ----------------------------------------------------------------------------
// gdr_out_if - result channel of the Gregorian date register
// Valid/ready handshake with the stored date, accepted flag and order.
// ----------------------------------------------------------------------------
interface gdr_out_if;
  logic                        valid;
  logic                        ready;
  logic [gdr_pkg::MONTH_W-1:0] cur_month;
  logic [gdr_pkg::DAY_W-1:0]   cur_day;
  logic [gdr_pkg::YEAR_W-1:0]  cur_year;
  logic                        accepted;
  logic [gdr_pkg::ORD_W-1:0]   order;

  modport source (output valid, cur_month, cur_day, cur_year, accepted, order,
                  input ready);
  modport sink   (input valid, cur_month, cur_day, cur_year, accepted, order,
                  output ready);
endinterface

### hdl/gregorian_date_register.sv
// ----------------------------------------------------------------------------
// gregorian_date_register - stored Gregorian date with set, advance, compare
//
// Usage:
//   in_ch carries one request per transaction: op selects set (load a date
//   after validation) or advance (move forward advance_days days); every
//   request also carries a compare date. out_ch returns one result per
//   request: the stored date, the accepted flag and the order against the
//   compare date.
//   Timing: a set checks and loads the date in the set state, then the
//   compare state hands the result to the output register. An advance steps
//   in the advance state, stopping early when it clamps at 31 Dec of the top
//   year; the day-step unit moves the date one day per cycle.
//   in_ch.ready is high only while no request is in progress; a new request
//   may be taken while the previous result still waits in the output
//   register.
//   Reset loads 1/1/2000 and empties the output register.
//   If the receiver stalls, the finished result holds in the output register;
//   a second finished result waits in the compare step until it drains.
// ----------------------------------------------------------------------------
module gregorian_date_register (
  input  logic       clk,
  input  logic       rst,
  gdr_in_if.sink     in_ch,
  gdr_out_if.source  out_ch
);

  // Sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SET  = 2'd1;
  localparam logic [1:0] S_ADV  = 2'd2;
  localparam logic [1:0] S_CMP  = 2'd3;

  logic [1:0] state;

  // Stored date
  logic [gdr_pkg::MONTH_W-1:0] month_reg;
  logic [gdr_pkg::DAY_W-1:0]   day_reg;
  logic [gdr_pkg::YEAR_W-1:0]  year_reg;

  // Captured request fields
  logic [gdr_pkg::MONTH_W-1:0] set_month;
  logic [gdr_pkg::DAY_W-1:0]   set_day;
  logic [gdr_pkg::YEAR_W-1:0]  set_year;
  logic [gdr_pkg::DAYS_W-1:0]  days_left;
  logic [gdr_pkg::MONTH_W-1:0] cmp_month;
  logic [gdr_pkg::DAY_W-1:0]   cmp_day;
  logic [gdr_pkg::YEAR_W-1:0]  cmp_year;
  logic                        acc;

  // Output register
  logic                        out_valid;
  logic [gdr_pkg::MONTH_W-1:0] out_month;
  logic [gdr_pkg::DAY_W-1:0]   out_day;
  logic [gdr_pkg::YEAR_W-1:0]  out_year;
  logic                        out_acc;
  logic [gdr_pkg::ORD_W-1:0]   out_order;

  logic in_take;
  logic out_free;
  logic at_limit;
  logic set_ok;
  logic [gdr_pkg::DAY_W-1:0]   day_inc;
  logic [gdr_pkg::DAY_W-1:0]   day_step;
  logic [gdr_pkg::MONTH_W-1:0] month_step;
  logic [gdr_pkg::YEAR_W-1:0]  year_step;
  logic [gdr_pkg::ORD_W-1:0]   order_now;

  assign in_ch.ready = (state == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  assign set_ok = gdr_pkg::date_valid(set_month, set_day, set_year);

  // Stop stepping once past the top year or on its last day
  assign at_limit = (year_reg > gdr_pkg::MAX_YEAR) ||
                    ((year_reg == gdr_pkg::MAX_YEAR) &&
                     (month_reg == gdr_pkg::LAST_MONTH) &&
                     (day_reg == gdr_pkg::LAST_DAY));

  // Day-step unit: advance the stored date by one day; roll over on the
  // last day of the month
  assign day_inc = day_reg + 5'd1;
  always_comb begin
    day_step   = day_inc;
    month_step = month_reg;
    year_step  = year_reg;
    if (day_reg >= gdr_pkg::month_length(month_reg, year_reg)) begin
      day_step = 5'd1;
      if (month_reg >= gdr_pkg::LAST_MONTH) begin
        month_step = 4'd1;
        year_step  = year_reg + 14'd1;
      end else begin
        month_step = month_reg + 4'd1;
      end
    end
  end

  // Order: year first, then month, then day, as raw numbers
  always_comb begin
    if ((year_reg < cmp_year) ||
        ((year_reg == cmp_year) && (month_reg < cmp_month)) ||
        ((year_reg == cmp_year) && (month_reg == cmp_month) && (day_reg < cmp_day))) begin
      order_now = gdr_pkg::ORD_EARLIER;
    end else if ((year_reg == cmp_year) && (month_reg == cmp_month) &&
                 (day_reg == cmp_day)) begin
      order_now = gdr_pkg::ORD_EQUAL;
    end else begin
      order_now = gdr_pkg::ORD_LATER;
    end
  end

  // Sequencer and stored date
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      month_reg <= gdr_pkg::RESET_MONTH;
      day_reg   <= gdr_pkg::RESET_DAY;
      year_reg  <= gdr_pkg::RESET_YEAR;
      acc       <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take) begin
            set_month <= in_ch.set_month;
            set_day   <= in_ch.set_day;
            set_year  <= in_ch.set_year;
            days_left <= in_ch.advance_days;
            cmp_month <= in_ch.cmp_month;
            cmp_day   <= in_ch.cmp_day;
            cmp_year  <= in_ch.cmp_year;
            acc       <= 1'b1;
            state     <= (in_ch.op == gdr_pkg::OP_ADVANCE) ? S_ADV : S_SET;
          end
        end
        S_SET: begin
          // Load the given date, or fall back to 1/1/2000
          if (set_ok) begin
            month_reg <= set_month;
            day_reg   <= set_day;
            year_reg  <= set_year;
          end else begin
            month_reg <= gdr_pkg::RESET_MONTH;
            day_reg   <= gdr_pkg::RESET_DAY;
            year_reg  <= gdr_pkg::RESET_YEAR;
            acc       <= 1'b0;
          end
          state <= S_CMP;
        end
        S_ADV: begin
          if (days_left == '0) begin
            state <= S_CMP;
          end else if (at_limit) begin
            acc   <= 1'b0;
            state <= S_CMP;
          end else begin
            month_reg <= month_step;
            day_reg   <= day_step;
            year_reg  <= year_step;
            days_left <= days_left - 16'd1;
          end
        end
        S_CMP: begin
          // Hold here until the output register can take the result
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_CMP) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_CMP) && out_free) begin
      out_month <= month_reg;
      out_day   <= day_reg;
      out_year  <= year_reg;
      out_acc   <= acc;
      out_order <= order_now;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.cur_month = out_month;
  assign out_ch.cur_day   = out_day;
  assign out_ch.cur_year  = out_year;
  assign out_ch.accepted  = out_acc;
  assign out_ch.order     = out_order;

endmodule

### sim/gdr_date_checker.sv
// ----------------------------------------------------------------------------
// gdr_date_checker - result checker for the Gregorian date register
// Watches both channels, keeps its own copy of the stored date, works out
// the result of every accepted request and compares returned results in
// order.
// ----------------------------------------------------------------------------
module gdr_date_checker (
  input  logic clk,
  input  logic rst,
  gdr_in_if    in_ch,
  gdr_out_if   out_ch,
  output int   err_count,
  output int   pending_count
);
  import gdr_pkg::*;

  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [YEAR_W-1:0]  year;
    logic               accepted;
    logic [ORD_W-1:0]   order;
  } date_result_t;

  date_result_t expected_dates[$];

  // Shadow copy of the stored date.
  int unsigned month_q;
  int unsigned day_q;
  int unsigned year_q;
  int          mismatches = 0;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    if (m == 2) return leap_year(y) ? 29 : 28;
    return 31;
  endfunction

  // Apply one request to the shadow date and return the result it causes.
  function automatic date_result_t apply_request(
    input logic op, input int unsigned sm, input int unsigned sd,
    input int unsigned sy, input int unsigned n, input int unsigned cm,
    input int unsigned cd, input int unsigned cy);
    date_result_t r;
    bit           ok;
    int unsigned  step;
    ok = 1'b1;
    if (op == OP_SET) begin
      if (sm >= 1 && sm <= LAST_MONTH &&
          !(sy < FIRST_YEAR || (sy == FIRST_YEAR && sm < FIRST_MONTH)) &&
          sd >= 1 && sd <= days_in(sm, sy)) begin
        month_q = sm;
        day_q   = sd;
        year_q  = sy;
      end else begin
        month_q = 32'(RESET_MONTH);
        day_q   = 32'(RESET_DAY);
        year_q  = 32'(RESET_YEAR);
        ok      = 1'b0;
      end
    end else begin
      for (step = 0; step < n; step++) begin
        // Stop at the last day of the top year, or refuse to move a date
        // that already lies beyond it.
        if (year_q > MAX_YEAR ||
            (year_q == MAX_YEAR && month_q == LAST_MONTH && day_q == LAST_DAY)) begin
          ok = 1'b0;
          break;
        end
        day_q++;
        if (day_q > days_in(month_q, year_q)) begin
          day_q = 1;
          month_q++;
          if (month_q > LAST_MONTH) begin
            month_q = 1;
            year_q++;
          end
        end
      end
    end
    r.month    = MONTH_W'(month_q);
    r.day      = DAY_W'(day_q);
    r.year     = YEAR_W'(year_q);
    r.accepted = ok;
    if (year_q < cy || (year_q == cy && month_q < cm) ||
        (year_q == cy && month_q == cm && day_q < cd))
      r.order = ORD_EARLIER;
    else if (year_q == cy && month_q == cm && day_q == cd)
      r.order = ORD_EQUAL;
    else
      r.order = ORD_LATER;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp,
                             input logic [15:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp, act);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    date_result_t exp;
    if (rst) begin
      month_q = 32'(RESET_MONTH);
      day_q   = 32'(RESET_DAY);
      year_q  = 32'(RESET_YEAR);
      expected_dates.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0d/%0d/%0d",
                   $time, out_ch.cur_month, out_ch.cur_day, out_ch.cur_year);
          mismatches++;
        end else begin
          exp = expected_dates.pop_front();
          check_field("cur_month", 16'(exp.month), 16'(out_ch.cur_month));
          check_field("cur_day", 16'(exp.day), 16'(out_ch.cur_day));
          check_field("cur_year", 16'(exp.year), 16'(out_ch.cur_year));
          check_field("accepted", 16'(exp.accepted), 16'(out_ch.accepted));
          check_field("order", 16'(exp.order), 16'(out_ch.order));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_dates.push_back(apply_request(in_ch.op, 32'(in_ch.set_month),
          32'(in_ch.set_day), 32'(in_ch.set_year), 32'(in_ch.advance_days),
          32'(in_ch.cmp_month), 32'(in_ch.cmp_day), 32'(in_ch.cmp_year)));
    end
    pending_count <= expected_dates.size();
    err_count     <= mismatches;
  end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for the Gregorian date register
// Drives set and advance requests, first a directed list of calendar corner
// cases, then random phases under different idling patterns and a long
// result hold-off; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import gdr_pkg::*;

  // Generous bound: worst advance counts plus stalls, taken several times.
  localparam int CYCLE_LIMIT    = 3000000;
  localparam int HOLDOFF_CYCLES = 3000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic               op;
    logic [MONTH_W-1:0] set_month;
    logic [DAY_W-1:0]   set_day;
    logic [YEAR_W-1:0]  set_year;
    logic [DAYS_W-1:0]  advance_days;
    logic [MONTH_W-1:0] cmp_month;
    logic [DAY_W-1:0]   cmp_day;
    logic [YEAR_W-1:0]  cmp_year;
  } date_req_t;

  logic clk;
  logic rst;
  int   err_count;
  int   pending_count;
  int   idle_pct;
  int   stall_pct;
  bit   holdoff_req;
  int   cycle_count;

  gdr_in_if  in_ch();
  gdr_out_if out_ch();

  gregorian_date_register dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gdr_date_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .err_count     (err_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side: stall at random, or hold ready low for a long stretch when
  // asked so that the block fills up and blocks its input.
  initial begin : result_sink
    int wait_left;
    wait_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        wait_left   = HOLDOFF_CYCLES;
      end
      if (rst || wait_left > 0) begin
        out_ch.ready <= 1'b0;
        if (wait_left > 0) wait_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Build a set request; the ignored day count carries noise.
  function automatic date_req_t set_req(
    input int unsigned m, input int unsigned d, input int unsigned y,
    input int unsigned cm, input int unsigned cd, input int unsigned cy);
    date_req_t r;
    r.op           = OP_SET;
    r.set_month    = MONTH_W'(m);
    r.set_day      = DAY_W'(d);
    r.set_year     = YEAR_W'(y);
    r.advance_days = DAYS_W'($urandom);
    r.cmp_month    = MONTH_W'(cm);
    r.cmp_day      = DAY_W'(cd);
    r.cmp_year     = YEAR_W'(cy);
    return r;
  endfunction

  // Build an advance request; the ignored set fields carry noise.
  function automatic date_req_t adv_req(
    input int unsigned n, input int unsigned cm, input int unsigned cd,
    input int unsigned cy);
    date_req_t r;
    r.op           = OP_ADVANCE;
    r.set_month    = MONTH_W'($urandom);
    r.set_day      = DAY_W'($urandom);
    r.set_year     = YEAR_W'($urandom);
    r.advance_days = DAYS_W'(n);
    r.cmp_month    = MONTH_W'(cm);
    r.cmp_day      = DAY_W'(cd);
    r.cmp_year     = YEAR_W'(cy);
    return r;
  endfunction

  // Offer one transaction after a random gap and hold it until taken.
  task automatic send_request(input date_req_t r);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= r.op;
    in_ch.set_month    <= r.set_month;
    in_ch.set_day      <= r.set_day;
    in_ch.set_year     <= r.set_year;
    in_ch.advance_days <= r.advance_days;
    in_ch.cmp_month    <= r.cmp_month;
    in_ch.cmp_day      <= r.cmp_day;
    in_ch.cmp_year     <= r.cmp_year;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and hold until every predicted result has come back. The
  // first edge lets the checker count the last accepted request.
  task automatic wait_all_returned();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Mostly well-formed dates followed by advances, some raw noise. Day
  // counts stay small except for one full-width count in every 25 items,
  // since an advance takes one cycle per day.
  task automatic send_random_items(input int count);
    date_req_t r;
    int        k;
    int        pick;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        r = set_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        r = set_req($urandom_range(12, 1),
                    ($urandom_range(9) == 0) ? $urandom_range(31, 29)
                                             : $urandom_range(28, 1),
                    (pick < 35) ? $urandom_range(MAX_YEAR, MAX_YEAR - 3) :
                    (pick < 40) ? $urandom_range(16383, 1582) :
                                  $urandom_range(2400, 1582),
                    0, 0, 0);
        // Compare against the date being set now and then, to hit equality.
        if ($urandom_range(99) < 40) begin
          r.cmp_month = r.set_month;
          r.cmp_day   = r.set_day;
          r.cmp_year  = r.set_year;
        end else begin
          r.cmp_month = MONTH_W'($urandom_range(12, 1));
          r.cmp_day   = DAY_W'($urandom_range(31, 1));
          r.cmp_year  = YEAR_W'($urandom_range(2400, 1582));
        end
      end
      if ($urandom_range(1) == 1) begin
        r.op           = OP_ADVANCE;
        r.advance_days = (k % 25 == 12) ? DAYS_W'($urandom)
                                        : DAYS_W'($urandom_range(1023));
      end
      send_request(r);
    end
  endtask

  initial begin
    int phase;
    idle_pct    = 0;
    stall_pct   = 0;
    holdoff_req = 1'b0;
    rst                <= 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_SET;
    in_ch.set_month    <= '0;
    in_ch.set_day      <= '0;
    in_ch.set_year     <= '0;
    in_ch.advance_days <= '0;
    in_ch.cmp_month    <= '0;
    in_ch.cmp_day      <= '0;
    in_ch.cmp_year     <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: leap rules, the calendar cutover, malformed fields,
    // compare extremes, rollover, and the clamp at the top year.
    send_request(set_req(2, 29, 2000, 2, 29, 2000));      // leap by 400
    send_request(set_req(2, 29, 1900, 15, 31, 16383));    // century, not leap
    send_request(set_req(2, 29, 2024, 0, 0, 0));          // plain leap year
    send_request(set_req(2, 29, 2023, 1, 1, 2000));       // not leap
    send_request(set_req(10, 1, 1582, 10, 2, 1582));      // first valid day
    send_request(set_req(9, 30, 1582, 1, 1, 1999));       // before cutover
    send_request(set_req(0, 15, 2010, 1, 1, 2000));       // month zero
    send_request(set_req(13, 1, 2010, 1, 1, 2000));       // month past 12
    send_request(set_req(15, 31, 16383, 1, 1, 2000));     // all ones
    send_request(set_req(4, 31, 2010, 1, 1, 2000));       // day past month end
    send_request(set_req(6, 0, 0, 1, 1, 2000));           // day and year zero
    send_request(set_req(2, 28, 2100, 2, 28, 2100));
    send_request(adv_req(1, 3, 1, 2100));                 // no leap day in 2100
    send_request(set_req(12, 31, 1999, 1, 1, 2000));
    send_request(adv_req(1, 1, 1, 2000));                 // year rollover
    send_request(adv_req(0, 1, 1, 2000));                 // zero days
    send_request(adv_req(366, 1, 1, 2001));               // across a leap year
    send_request(set_req(12, 31, 16383, 12, 31, 16383));  // valid beyond top
    send_request(adv_req(5, 1, 1, 2000));                 // stuck beyond top
    send_request(adv_req(0, 12, 31, 16383));              // zero days beyond top
    send_request(set_req(12, 31, MAX_YEAR, 12, 31, MAX_YEAR));
    send_request(adv_req(1, 12, 31, MAX_YEAR));           // clamp at once
    send_request(set_req(12, 1, 9900, 1, 1, 9900));
    send_request(adv_req(65535, 12, 31, MAX_YEAR));       // clamp after years
    wait_all_returned();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 85;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 85;
        end
        default: begin
          idle_pct  = 22;
          stall_pct = 22;
        end
      endcase
      send_random_items(17);
      wait_all_returned();
    end

    // Long hold-off on the result side while requests keep coming, so the
    // output register and the compare step fill and the input blocks.
    idle_pct    = 0;
    stall_pct   = 0;
    holdoff_req = 1'b1;
    send_random_items(8);
    wait_all_returned();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
